// ===== rtl/rth_pkg.sv =====
`timescale 1ns / 1ps
package rth_pkg;

   localparam int CW            = 32;
   localparam int EW            = CW + 1;
   localparam int FRAC_BITS_DEF = 16;
   localparam int TOL_W         = 16;
   localparam int TOL_RESET     = 1;
   localparam int FIFO_DEPTH    = 4;
   localparam int CSR_DW        = 32;
   localparam int CSR_AW        = 3;
   localparam int REG_TOL       = 0;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TEST = 1'b1
   } rth_op_type;

   typedef struct packed {
      rth_op_type             op;
      logic signed [CW-1:0]   vert_a_x;
      logic signed [CW-1:0]   vert_a_y;
      logic signed [CW-1:0]   vert_a_z;
      logic signed [CW-1:0]   vert_b_x;
      logic signed [CW-1:0]   vert_b_y;
      logic signed [CW-1:0]   vert_b_z;
      logic signed [CW-1:0]   vert_c_x;
      logic signed [CW-1:0]   vert_c_y;
      logic signed [CW-1:0]   vert_c_z;
   } rth_req_type;

   typedef struct packed {
      logic                   hit;
      logic signed [CW-1:0]   hit_distance;
      logic signed [CW-1:0]   weight_first;
      logic signed [CW-1:0]   weight_second;
      logic signed [CW-1:0]   weight_third;
   } rth_rsp_type;

   // one queued triangle test: edges, offset from ray origin, ray direction
   typedef struct packed {
      logic [2:0][EW-1:0]     e0;
      logic [2:0][EW-1:0]     e1;
      logic [2:0][EW-1:0]     org_ofs;
      logic [2:0][CW-1:0]     dir;
   } rth_entry_type;

   typedef struct packed {
      logic                   pop;
      logic                   not_empty;
   } rth_qctl_type;

endpackage

// ===== rtl/ray_triangle_hit_test_top.sv =====
`timescale 1ns / 1ps
// Ray/triangle hit test. A beat with op LOAD replaces the held ray and gives no
// result; each TEST beat gives exactly one result, in order. One triangle is
// taken per cycle when the result side keeps up; the front loads the ray and
// forms edges into a four-entry queue, and the back is a fully pipelined
// datapath whose depth is set by the three floor dividers, one quotient bit per
// stage.
// A stall on rsp_ready freezes the back pipeline; the queue lets the front keep
// taking beats until it is full. edge_tolerance sits at byte address 0.
module ray_triangle_hit_test_top #(
   parameter int FRAC_BITS = rth_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rth_pkg::rth_req_type       req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rth_pkg::rth_rsp_type       rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rth_pkg::CSR_AW-1:0] paddr,
   input  logic [rth_pkg::CSR_DW-1:0] pwdata,
   output logic [rth_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);
   import rth_pkg::*;

   logic             tol_sel;
   logic [TOL_W-1:0] tol_ff, tol_in;
   logic             push;
   logic             full;
   logic             not_empty;
   rth_entry_type    push_data;
   rth_entry_type    pop_data;
   rth_qctl_type     qctl;

   assign pready  = 1'b1;
   assign tol_sel = (paddr[CSR_AW-1:2] == 1'(REG_TOL));
   assign prdata  = tol_sel ? CSR_DW'(tol_ff) : '0;

   always_comb begin
      tol_in = tol_ff;
      if (psel && penable && pwrite && tol_sel) begin
         tol_in = pwdata[TOL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_W'(TOL_RESET);
      end else begin
         tol_ff <= tol_in;
      end
   end

   rth_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   rth_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .ctl_in    (qctl),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   rth_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .entry     (pop_data),
      .qctl      (qctl),
      .tol       (tol_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/rth_front.sv =====
`timescale 1ns / 1ps
module rth_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rth_pkg::rth_req_type  req_data,
   output logic                  push,
   output rth_pkg::rth_entry_type push_data,
   input  logic                  full
);
   import rth_pkg::*;

   logic [2:0][CW-1:0] origin_ff, origin_in;
   logic [2:0][CW-1:0] dir_ff, dir_in;
   logic               take;
   logic signed [CW-1:0] va [3];
   logic signed [CW-1:0] vb [3];
   logic signed [CW-1:0] vc [3];
   logic signed [CW-1:0] org [3];

   assign req_ready = !full;
   assign take      = req_valid && !full;
   assign push      = take && (req_data.op == OP_TEST);

   always_comb begin
      va[0] = req_data.vert_a_x;
      va[1] = req_data.vert_a_y;
      va[2] = req_data.vert_a_z;
      vb[0] = req_data.vert_b_x;
      vb[1] = req_data.vert_b_y;
      vb[2] = req_data.vert_b_z;
      vc[0] = req_data.vert_c_x;
      vc[1] = req_data.vert_c_y;
      vc[2] = req_data.vert_c_z;
      origin_in = origin_ff;
      dir_in    = dir_ff;
      if (take && (req_data.op == OP_LOAD)) begin
         origin_in = {va[2], va[1], va[0]};
         dir_in    = {vb[2], vb[1], vb[0]};
      end
      for (int i = 0; i < 3; i++) begin
         org[i]                = $signed(origin_ff[i]);
         push_data.e0[i]       = EW'(vb[i]) - EW'(va[i]);
         push_data.e1[i]       = EW'(va[i]) - EW'(vc[i]);
         push_data.org_ofs[i]  = EW'(va[i]) - EW'(org[i]);
         push_data.dir[i]      = dir_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         dir_ff    <= '0;
      end else begin
         origin_ff <= origin_in;
         dir_ff    <= dir_in;
      end
   end

endmodule

// ===== rtl/rth_fifo.sv =====
`timescale 1ns / 1ps
module rth_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rth_pkg::rth_entry_type push_data,
   output logic                   full,
   input  rth_pkg::rth_qctl_type  ctl_in,
   output logic                   not_empty,
   output rth_pkg::rth_entry_type pop_data
);
   import rth_pkg::*;

   localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

   rth_entry_type   slot_ff [FIFO_DEPTH];
   logic [AW-1:0]   wr_ff, wr_in;
   logic [AW-1:0]   rd_ff, rd_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic            pop;

   assign pop       = ctl_in.pop;
   assign full      = (cnt_ff == (AW+1)'(FIFO_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/rth_div.sv =====
`timescale 1ns / 1ps
// Floor division, one quotient bit per stage.
module rth_div #(
   parameter int NW = 118,
   parameter int DW = 101
) (
   input  logic                 clock,
   input  logic                 adv,
   input  logic signed [NW-1:0] num,
   input  logic signed [DW-1:0] den,
   output logic signed [NW:0]   quo
);

   logic [NW-1:0]      nq_ff  [NW+1];
   logic [DW-1:0]      rem_ff [NW+1];
   logic [DW-1:0]      ud_ff  [NW+1];
   logic               neg_ff [NW+1];
   logic signed [NW:0] mag;
   logic signed [NW:0] quo_in, quo_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         nq_ff[0]  <= num[NW-1] ? NW'(-num) : num;
         rem_ff[0] <= '0;
         ud_ff[0]  <= den[DW-1] ? DW'(-den) : den;
         neg_ff[0] <= num[NW-1] ^ den[DW-1];
      end
   end

   for (genvar k = 0; k < NW; k++) begin : g_step
      logic [DW:0]   shifted;
      logic [DW-1:0] diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] nq_in;
      always_comb begin
         shifted = {rem_ff[k], nq_ff[k][NW-1]};
         ge      = (shifted >= {1'b0, ud_ff[k]});
         diff    = shifted[DW-1:0] - ud_ff[k];
         rem_in  = ge ? diff : shifted[DW-1:0];
         nq_in   = {nq_ff[k][NW-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            nq_ff[k+1]  <= nq_in;
            rem_ff[k+1] <= rem_in;
            ud_ff[k+1]  <= ud_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   always_comb begin
      mag    = {1'b0, nq_ff[NW]};
      quo_in = neg_ff[NW] ? (-mag - (NW+1)'(rem_ff[NW] != '0)) : mag;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

// ===== rtl/rth_back.sv =====
`timescale 1ns / 1ps
module rth_back #(
   parameter int FRAC_BITS = rth_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      not_empty,
   input  rth_pkg::rth_entry_type    entry,
   output rth_pkg::rth_qctl_type     qctl,
   input  logic [rth_pkg::TOL_W-1:0] tol,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rth_pkg::rth_rsp_type      rsp_data
);
   import rth_pkg::*;

   localparam int PNW     = 2 * EW;
   localparam int NRW     = PNW + 1;
   localparam int PQW     = CW + EW;
   localparam int QW      = PQW + 1;
   localparam int NLO     = NRW / 2;
   localparam int QLO     = QW / 2;
   localparam int DLW     = NLO + 1 + CW;
   localparam int DHW     = NRW - NLO + CW;
   localparam int ALW     = QLO + 1 + EW;
   localparam int AHW     = QW - QLO + EW;
   localparam int TLW     = NLO + 1 + EW;
   localparam int THW     = NRW - NLO + EW;
   localparam int DPW     = NRW + CW;
   localparam int APW     = QW + EW;
   localparam int TPW     = NRW + EW;
   localparam int DETW    = DPW + 2;
   localparam int AW      = APW + 2;
   localparam int TW      = TPW + 2;
   localparam int NUMW    = ((AW > TW) ? AW : TW) + FRAC_BITS;
   localparam int XW      = NUMW + 3;
   localparam int DIV_LAT = NUMW + 2;
   localparam logic signed [XW-1:0] ONE_FX = XW'(1) <<< FRAC_BITS;

   logic adv;

   // stage 0: queue head as signed vectors
   logic signed [EW-1:0] e0_0 [3];
   logic signed [EW-1:0] e1_0 [3];
   logic signed [EW-1:0] o_0  [3];
   logic signed [CW-1:0] d_0  [3];

   // stage 1: cross-product terms
   logic                 vld_s1_ff;
   logic signed [PNW-1:0] pn_ff [6];
   logic signed [PQW-1:0] pq_ff [6];
   logic signed [EW-1:0] e0_s1_ff [3];
   logic signed [EW-1:0] e1_s1_ff [3];
   logic signed [EW-1:0] o_s1_ff  [3];
   logic signed [CW-1:0] d_s1_ff  [3];

   // stage 2: normal and q
   logic                 vld_s2_ff;
   logic signed [NRW-1:0] nrm_ff [3];
   logic signed [QW-1:0] qv_ff [3];
   logic signed [EW-1:0] e0_s2_ff [3];
   logic signed [EW-1:0] e1_s2_ff [3];
   logic signed [EW-1:0] o_s2_ff  [3];
   logic signed [CW-1:0] d_s2_ff  [3];

   // stage 3: split partial products
   logic                 vld_s3_ff;
   logic signed [DLW-1:0] dl_ff [3];
   logic signed [DHW-1:0] dh_ff [3];
   logic signed [ALW-1:0] l2_ff [3];
   logic signed [AHW-1:0] h2_ff [3];
   logic signed [ALW-1:0] l3_ff [3];
   logic signed [AHW-1:0] h3_ff [3];
   logic signed [TLW-1:0] tl_ff [3];
   logic signed [THW-1:0] th_ff [3];

   // stage 4: full products
   logic                 vld_s4_ff;
   logic signed [DPW-1:0] dp_ff [3];
   logic signed [APW-1:0] p2_ff [3];
   logic signed [APW-1:0] p3_ff [3];
   logic signed [TPW-1:0] tp_ff [3];

   // stage 5: dot products
   logic                 vld_s5_ff;
   logic signed [DETW-1:0] det_ff;
   logic signed [AW-1:0] a2_ff;
   logic signed [AW-1:0] a3_ff;
   logic signed [TW-1:0] tn_ff;

   logic signed [NUMW-1:0] num2, num3, numt;
   logic signed [NUMW:0]   q2, q3, qt;
   logic                   vld_d_ff [DIV_LAT];
   logic                   dz_d_ff  [DIV_LAT];

   // stage 6: all three weights and the distance
   logic                 vld_s6_ff;
   logic                 dz_s6_ff;
   logic signed [XW-1:0] w1_s6_ff, w2_s6_ff, w3_s6_ff, t_s6_ff;

   logic                 out_vld_ff;
   rth_rsp_type          out_ff, out_in;
   logic signed [XW-1:0] ntol;
   logic                 hit;

   function automatic logic [CW-1:0] sat(input logic signed [XW-1:0] v);
      logic [XW-CW:0] top;
      top = v[XW-1:CW-1];
      if ((top == '0) || (top == '1)) begin
         return v[CW-1:0];
      end
      return v[XW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
   endfunction

   assign adv            = !out_vld_ff || rsp_ready;
   assign qctl.pop       = adv && not_empty;
   assign qctl.not_empty = not_empty;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e0_0[i] = $signed(entry.e0[i]);
         e1_0[i] = $signed(entry.e1[i]);
         o_0[i]  = $signed(entry.org_ofs[i]);
         d_0[i]  = $signed(entry.dir[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pn_ff[0] <= e1_0[1] * e0_0[2];
         pn_ff[1] <= e1_0[2] * e0_0[1];
         pn_ff[2] <= e1_0[2] * e0_0[0];
         pn_ff[3] <= e1_0[0] * e0_0[2];
         pn_ff[4] <= e1_0[0] * e0_0[1];
         pn_ff[5] <= e1_0[1] * e0_0[0];
         pq_ff[0] <= d_0[1] * o_0[2];
         pq_ff[1] <= d_0[2] * o_0[1];
         pq_ff[2] <= d_0[2] * o_0[0];
         pq_ff[3] <= d_0[0] * o_0[2];
         pq_ff[4] <= d_0[0] * o_0[1];
         pq_ff[5] <= d_0[1] * o_0[0];
         for (int i = 0; i < 3; i++) begin
            e0_s1_ff[i] <= e0_0[i];
            e1_s1_ff[i] <= e1_0[i];
            o_s1_ff[i]  <= o_0[i];
            d_s1_ff[i]  <= d_0[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            nrm_ff[i]   <= NRW'(pn_ff[2*i]) - NRW'(pn_ff[2*i+1]);
            qv_ff[i]    <= QW'(pq_ff[2*i]) - QW'(pq_ff[2*i+1]);
            e0_s2_ff[i] <= e0_s1_ff[i];
            e1_s2_ff[i] <= e1_s1_ff[i];
            o_s2_ff[i]  <= o_s1_ff[i];
            d_s2_ff[i]  <= d_s1_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dl_ff[i] <= $signed({1'b0, nrm_ff[i][NLO-1:0]}) * d_s2_ff[i];
            dh_ff[i] <= $signed(nrm_ff[i][NRW-1:NLO]) * d_s2_ff[i];
            l2_ff[i] <= $signed({1'b0, qv_ff[i][QLO-1:0]}) * e1_s2_ff[i];
            h2_ff[i] <= $signed(qv_ff[i][QW-1:QLO]) * e1_s2_ff[i];
            l3_ff[i] <= $signed({1'b0, qv_ff[i][QLO-1:0]}) * e0_s2_ff[i];
            h3_ff[i] <= $signed(qv_ff[i][QW-1:QLO]) * e0_s2_ff[i];
            tl_ff[i] <= $signed({1'b0, nrm_ff[i][NLO-1:0]}) * o_s2_ff[i];
            th_ff[i] <= $signed(nrm_ff[i][NRW-1:NLO]) * o_s2_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dp_ff[i] <= (DPW'(dh_ff[i]) <<< NLO) + DPW'(dl_ff[i]);
            p2_ff[i] <= (APW'(h2_ff[i]) <<< QLO) + APW'(l2_ff[i]);
            p3_ff[i] <= (APW'(h3_ff[i]) <<< QLO) + APW'(l3_ff[i]);
            tp_ff[i] <= (TPW'(th_ff[i]) <<< NLO) + TPW'(tl_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         det_ff <= DETW'(dp_ff[0]) + DETW'(dp_ff[1]) + DETW'(dp_ff[2]);
         a2_ff  <= AW'(p2_ff[0]) + AW'(p2_ff[1]) + AW'(p2_ff[2]);
         a3_ff  <= AW'(p3_ff[0]) + AW'(p3_ff[1]) + AW'(p3_ff[2]);
         tn_ff  <= TW'(tp_ff[0]) + TW'(tp_ff[1]) + TW'(tp_ff[2]);
      end
   end

   assign num2 = NUMW'(a2_ff) <<< FRAC_BITS;
   assign num3 = NUMW'(a3_ff) <<< FRAC_BITS;
   assign numt = NUMW'(tn_ff) <<< FRAC_BITS;

   rth_div #(.NW(NUMW), .DW(DETW)) u_div_w2 (
      .clock (clock), .adv (adv), .num (num2), .den (det_ff), .quo (q2)
   );
   rth_div #(.NW(NUMW), .DW(DETW)) u_div_w3 (
      .clock (clock), .adv (adv), .num (num3), .den (det_ff), .quo (q3)
   );
   rth_div #(.NW(NUMW), .DW(DETW)) u_div_t (
      .clock (clock), .adv (adv), .num (numt), .den (det_ff), .quo (qt)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         dz_d_ff[0] <= (det_ff == '0);
         for (int k = 1; k < DIV_LAT; k++) begin
            dz_d_ff[k] <= dz_d_ff[k-1];
         end
         dz_s6_ff <= dz_d_ff[DIV_LAT-1];
         w2_s6_ff <= XW'(q2);
         w3_s6_ff <= XW'(q3);
         t_s6_ff  <= XW'(qt);
         w1_s6_ff <= ONE_FX - XW'(q2) - XW'(q3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_s1_ff  <= 1'b0;
         vld_s2_ff  <= 1'b0;
         vld_s3_ff  <= 1'b0;
         vld_s4_ff  <= 1'b0;
         vld_s5_ff  <= 1'b0;
         vld_s6_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int k = 0; k < DIV_LAT; k++) begin
            vld_d_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_s1_ff  <= not_empty;
         vld_s2_ff  <= vld_s1_ff;
         vld_s3_ff  <= vld_s2_ff;
         vld_s4_ff  <= vld_s3_ff;
         vld_s5_ff  <= vld_s4_ff;
         vld_d_ff[0] <= vld_s5_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            vld_d_ff[k] <= vld_d_ff[k-1];
         end
         vld_s6_ff  <= vld_d_ff[DIV_LAT-1];
         out_vld_ff <= vld_s6_ff;
      end
   end

   always_comb begin
      ntol = -XW'(tol);
      hit  = !dz_s6_ff && (w1_s6_ff >= ntol) && (w2_s6_ff >= ntol) &&
             (w3_s6_ff >= ntol) && !t_s6_ff[XW-1];
      out_in.hit           = hit;
      out_in.hit_distance  = hit ? sat(t_s6_ff) : '0;
      out_in.weight_first  = dz_s6_ff ? '0 : sat(w1_s6_ff);
      out_in.weight_second = dz_s6_ff ? '0 : sat(w2_s6_ff);
      out_in.weight_third  = dz_s6_ff ? '0 : sat(w3_s6_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/rth_checker.sv =====
`timescale 1ns / 1ps
module rth_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rth_pkg::rth_rsp_type rsp_data
);
   import rth_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_hit_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |->
         !rsp_data.hit_distance[CW-1] &&
         (rsp_data.weight_first >= -(CW'(2**TOL_W - 1))) &&
         (rsp_data.weight_second >= -(CW'(2**TOL_W - 1))) &&
         (rsp_data.weight_third >= -(CW'(2**TOL_W - 1))))
      else $error("hit with negative distance or weight below tolerance");

   a_miss_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> (rsp_data.hit_distance == '0))
      else $error("miss with nonzero distance");

endmodule

bind ray_triangle_hit_test_top rth_checker u_rth_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_ray_triangle_hit_test_top.sv =====
`timescale 1ns / 1ps
module tb_ray_triangle_hit_test_top;
   import rth_pkg::*;

   localparam int LAT        = 2 * FRAC_BITS_DEF + 110;
   localparam int CYCLE_LIMIT = 900000;
   localparam int WW         = 160;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   rth_req_type       req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rth_rsp_type       rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   ray_triangle_hit_test_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   rth_req_type       pending_beats[$];
   rth_rsp_type       expected_hits[$];
   logic signed [CW-1:0] ray_org[3];
   logic signed [CW-1:0] ray_dir[3];
   logic signed [CW-1:0] ray_plan_x, ray_plan_y;
   logic [TOL_W-1:0]  tolerance;
   int                mismatches = 0;
   int                cycles = 0;
   bit                hold_off = 1'b0;
   bit                req_taken = 1'b0;
   int                send_gap = 0;
   int                recv_gap = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [WW-1:0] floor_div(logic signed [WW-1:0] n,
                                                      logic signed [WW-1:0] d);
      logic signed [WW-1:0] q;
      q = n / d;
      if ((n % d != 0) && ((n < 0) != (d < 0))) q = q - 1;
      return q;
   endfunction

   function automatic logic signed [CW-1:0] clamp(logic signed [WW-1:0] v);
      logic signed [WW-1:0] hi, lo;
      hi = (WW'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi[CW-1:0];
      if (v < lo) return lo[CW-1:0];
      return v[CW-1:0];
   endfunction

   // updates the held ray on a load, returns 1 with the result on a test
   function automatic bit trace_triangle(rth_req_type b, output rth_rsp_type r);
      logic signed [WW-1:0] a[3], bv[3], c[3], e0[3], e1[3], o[3], d[3];
      logic signed [WW-1:0] n[3], q[3], det, w1, w2, w3, t, ntol;
      r = '0;
      if (b.op == OP_LOAD) begin
         ray_org = '{b.vert_a_x, b.vert_a_y, b.vert_a_z};
         ray_dir = '{b.vert_b_x, b.vert_b_y, b.vert_b_z};
         return 1'b0;
      end
      a  = '{WW'(b.vert_a_x), WW'(b.vert_a_y), WW'(b.vert_a_z)};
      bv = '{WW'(b.vert_b_x), WW'(b.vert_b_y), WW'(b.vert_b_z)};
      c  = '{WW'(b.vert_c_x), WW'(b.vert_c_y), WW'(b.vert_c_z)};
      for (int i = 0; i < 3; i++) begin
         e0[i] = bv[i] - a[i];
         e1[i] = a[i] - c[i];
         o[i]  = a[i] - WW'(ray_org[i]);
         d[i]  = WW'(ray_dir[i]);
      end
      n[0] = e1[1] * e0[2] - e1[2] * e0[1];
      n[1] = e1[2] * e0[0] - e1[0] * e0[2];
      n[2] = e1[0] * e0[1] - e1[1] * e0[0];
      det = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
      if (det == 0) return 1'b1;
      q[0] = d[1] * o[2] - d[2] * o[1];
      q[1] = d[2] * o[0] - d[0] * o[2];
      q[2] = d[0] * o[1] - d[1] * o[0];
      w2 = floor_div((q[0] * e1[0] + q[1] * e1[1] + q[2] * e1[2]) <<< FRAC_BITS_DEF, det);
      w3 = floor_div((q[0] * e0[0] + q[1] * e0[1] + q[2] * e0[2]) <<< FRAC_BITS_DEF, det);
      w1 = (WW'(1) <<< FRAC_BITS_DEF) - w2 - w3;
      t  = floor_div((n[0] * o[0] + n[1] * o[1] + n[2] * o[2]) <<< FRAC_BITS_DEF, det);
      ntol = -WW'(tolerance);
      r.hit = (w1 >= ntol) && (w2 >= ntol) && (w3 >= ntol) && (t >= 0);
      r.hit_distance  = r.hit ? clamp(t) : '0;
      r.weight_first  = clamp(w1);
      r.weight_second = clamp(w2);
      r.weight_third  = clamp(w3);
      return 1'b1;
   endfunction

   // acceptance is taken at the rising edge
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            rth_rsp_type r;
            if (trace_triangle(req_data, r)) expected_hits.push_back(r);
         end
         if (req_valid && !req_taken) begin
         end else if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (!hold_off && pending_beats.size() > 0) begin
            req_data  <= pending_beats.pop_front();
            req_valid <= 1'b1;
            send_gap  <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
         if (recv_gap > 0) begin
            rsp_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) recv_gap <= pick_gap();
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hits.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected beat %p", rsp_data);
         end else begin
            rth_rsp_type e;
            e = expected_hits.pop_front();
            if (e !== rsp_data) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("mismatch exp %p got %p", e, rsp_data);
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic csr_write(logic [15:0] v);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= CSR_AW'(REG_TOL * 4); pwdata <= CSR_DW'(v);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      tolerance = v;
   endtask

   task automatic drain();
      while (pending_beats.size() > 0 || req_valid || expected_hits.size() > 0)
         @(posedge clock);
      repeat (LAT) @(posedge clock);
   endtask

   function automatic logic signed [CW-1:0] rnd_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return CW'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
         default: return CW'($signed($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   function automatic rth_req_type rand_beat(bit load);
      rth_req_type b;
      int mode;
      mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
      b.op = load ? OP_LOAD : OP_TEST;
      b.vert_a_x = rnd_coord(mode); b.vert_a_y = rnd_coord(mode);
      b.vert_a_z = rnd_coord(mode); b.vert_b_x = rnd_coord(mode);
      b.vert_b_y = rnd_coord(mode); b.vert_b_z = rnd_coord(mode);
      b.vert_c_x = rnd_coord(mode); b.vert_c_y = rnd_coord(mode);
      b.vert_c_z = rnd_coord(mode);
      return b;
   endfunction

   // triangle straddling the held ray: likely hits
   function automatic rth_req_type aimed_tri();
      rth_req_type b;
      int s;
      s = $urandom_range(1, 8) * 65536;
      b.op = OP_TEST;
      b.vert_a_x = ray_plan_x - s; b.vert_a_y = ray_plan_y - s; b.vert_a_z = $urandom_range(1, 20) * 65536;
      b.vert_b_x = ray_plan_x + s; b.vert_b_y = ray_plan_y - s; b.vert_b_z = b.vert_a_z + CW'($urandom_range(0, 4096));
      b.vert_c_x = ray_plan_x;     b.vert_c_y = ray_plan_y + s; b.vert_c_z = b.vert_a_z - CW'($urandom_range(0, 4096));
      if ($urandom_range(0, 1)) b.vert_a_z = -b.vert_a_z;
      return b;
   endfunction

   localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] ONE  = 32'sd65536;

   initial begin
      rth_req_type b;
      logic [15:0] tols[5];
      tolerance = TOL_W'(TOL_RESET);
      ray_org = '{default: '0};
      ray_dir = '{default: '0};
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: test with reset ray (zero determinant), then load and extremes
      b = '0; b.op = OP_TEST; b.vert_b_x = ONE; b.vert_c_y = ONE;
      pending_beats.push_back(b);
      b = '0; b.op = OP_LOAD; b.vert_b_z = ONE; b.vert_c_x = MAXC;
      pending_beats.push_back(b);
      b = '0; b.op = OP_TEST; b.vert_a_z = 5 * ONE; b.vert_b_x = ONE; b.vert_b_z = 5 * ONE;
      b.vert_c_y = ONE; b.vert_c_z = 5 * ONE;
      pending_beats.push_back(b);               // hit at corner
      b.vert_a_z = -5 * ONE; b.vert_b_z = -5 * ONE; b.vert_c_z = -5 * ONE;
      pending_beats.push_back(b);               // behind the ray
      b = '0; b.op = OP_TEST; b.vert_a_x = -ONE; b.vert_a_y = -ONE; b.vert_b_x = ONE;
      b.vert_b_y = -ONE; b.vert_c_y = ONE; b.vert_a_z = 3; b.vert_b_z = 3; b.vert_c_z = 3;
      pending_beats.push_back(b);               // tiny distance
      b = '0; b.op = OP_TEST; b.vert_a_x = ONE; b.vert_b_x = ONE; b.vert_c_x = ONE;
      b.vert_b_y = ONE; b.vert_c_z = ONE;
      pending_beats.push_back(b);               // parallel plane
      b = '0; b.op = OP_TEST; b.vert_a_x = MAXC; b.vert_a_y = MINC; b.vert_a_z = MAXC;
      b.vert_b_x = MINC; b.vert_b_y = MAXC; b.vert_b_z = MINC;
      b.vert_c_x = MAXC; b.vert_c_y = MAXC; b.vert_c_z = MINC;
      pending_beats.push_back(b);
      b = '0; b.op = OP_TEST; b.vert_a_z = MAXC; b.vert_b_x = 1; b.vert_b_z = MAXC;
      b.vert_c_y = 1; b.vert_c_z = MAXC;
      pending_beats.push_back(b);               // saturated distance
      b = '0; b.op = OP_LOAD; b.vert_a_x = MINC; b.vert_a_y = MAXC; b.vert_a_z = MINC;
      b.vert_b_x = MAXC; b.vert_b_y = MINC; b.vert_b_z = MAXC;
      pending_beats.push_back(b);
      for (int i = 0; i < 4; i++) pending_beats.push_back(rand_beat(1'b0));
      b = '1; b.op = OP_LOAD; pending_beats.push_back(b);
      b = '1; b.op = OP_TEST; pending_beats.push_back(b);
      drain();

      tols = '{16'd0, 16'd65535, 16'd1, 16'd300, 16'd4096};
      for (int ph = 0; ph < 5; ph++) begin
         csr_write(tols[ph]);
         for (int n = 0; n < 350; n++) begin
            if (n % 40 == 0) begin
               b = '0; b.op = OP_LOAD;
               ray_plan_x = rnd_coord(1); ray_plan_y = rnd_coord(1);
               b.vert_a_x = ray_plan_x; b.vert_a_y = ray_plan_y;
               b.vert_a_z = rnd_coord(2);
               b.vert_b_x = rnd_coord(2) >>> 4; b.vert_b_y = rnd_coord(2) >>> 4;
               b.vert_b_z = $urandom_range(0, 1) ? ONE : -ONE;
               b.vert_c_x = $urandom; b.vert_c_y = $urandom; b.vert_c_z = $urandom;
               pending_beats.push_back(b);
            end else if ($urandom_range(0, 99) < 60) begin
               pending_beats.push_back(aimed_tri());
            end else begin
               pending_beats.push_back(rand_beat($urandom_range(0, 19) == 0));
            end
            if (ph == 2 && n == 175) begin
               while (pending_beats.size() > 0 || req_valid) @(posedge clock);
               hold_off = 1'b1;
               while (expected_hits.size() > 0) @(posedge clock);
               hold_off = 1'b0;
            end
         end
         drain();
      end

      if (mismatches == 0 && expected_hits.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
